>>> rtl/tuner_note_classifier_assert.svh
// assertion macros for the tuner note classifier checker
// implication in the same cycle, and implication into the next cycle
`ifndef TUNER_NOTE_CLASSIFIER_ASSERT_SVH
`define TUNER_NOTE_CLASSIFIER_ASSERT_SVH

`define TNC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define TNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tnc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnc_pkg
// types and constants shared by the tuner note classifier modules
// ----------------------------------------------------------------------------
package tnc_pkg;

  localparam int FREQ_W  = 16;
  localparam int LABEL_W = 24;
  localparam int TEXT_W  = 32;
  localparam int MARGIN_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // request codes
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_FIND   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN   = 2'd2;

  // pitch status codes
  localparam logic [1:0] ST_FLAT   = 2'd0;
  localparam logic [1:0] ST_SHARP  = 2'd1;
  localparam logic [1:0] ST_INTUNE = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  // color codes
  localparam logic [1:0] COL_RED   = 2'd0;
  localparam logic [1:0] COL_GREEN = 2'd1;
  localparam logic [1:0] COL_WHITE = 2'd2;

  // characters
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [TEXT_W-1:0] TEXT_NONE = 32'h6E6F6E65;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [FREQ_W-1:0]  frequency_hz;
    logic [LABEL_W-1:0] tone_label;
  } tnc_in_t;

  typedef struct packed {
    logic [TEXT_W-1:0] display_text;
    logic [1:0]        pitch_status;
    logic [1:0]        color_code;
  } tnc_out_t;

  // query travelling down the cell row
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic [FREQ_W-1:0]  freq;
    logic [FREQ_W-1:0]  tone;
    logic [LABEL_W-1:0] label;
  } token_t;

  // per-cell control from the entry count
  typedef struct packed {
    logic active;
    logic use_min;
    logic use_max;
  } cell_ctl_t;

endpackage

>>> rtl/tuner_note_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuner_note_classifier
// note table with band lookup: a row of entry cells scanned by a travelling token
// ----------------------------------------------------------------------------
// clear and append take effect at the accepting edge; busy stays low
// find: out_valid strobes once the token has passed every cell register and the result register, busy high until then
// no new transaction is accepted while a find walks down the cells
// the receiver cannot stall; a result is shown for exactly one cycle
// synchronous active-low reset: table empty, min 0, max 65535, margin 2
// table contents are not cleared by reset, only the entry count
module tuner_note_classifier
  import tnc_pkg::*;
#(
  parameter int MAX_TONES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input transaction
  input  logic                  start,
  output logic                  busy,
  input  tnc_in_t               in_data,
  // result transaction
  output logic                  out_valid,
  output tnc_out_t              out_data,
  // configuration writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_TONES + 1);

  // configuration registers
  logic [FREQ_W-1:0]   min_freq_r;
  logic [FREQ_W-1:0]   max_freq_r;
  logic [MARGIN_W-1:0] margin_r;

  // control
  logic [CNT_W-1:0] entry_count_r, entry_count_nxt;
  logic             busy_r, busy_nxt;

  logic in_acc, clear_acc, append_acc, find_acc;

  // cell row wiring
  token_t            tok [0:MAX_TONES];
  logic [FREQ_W-1:0] tone_w [0:MAX_TONES-1];

  assign in_acc     = start && !busy_r;
  assign clear_acc  = in_acc && (in_data.req_type == REQ_CLEAR);
  // append only while there is room, a full table drops it
  assign append_acc = in_acc && (in_data.req_type == REQ_APPEND) &&
                      (entry_count_r < CNT_W'(MAX_TONES));
  assign find_acc   = in_acc && (in_data.req_type == REQ_FIND);

  // configuration port, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_freq_r <= '0;
      max_freq_r <= '1;
      margin_r   <= MARGIN_W'(2);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MIN_FREQ: min_freq_r <= cfg_wdata[FREQ_W-1:0];
        CFG_MAX_FREQ: max_freq_r <= cfg_wdata[FREQ_W-1:0];
        CFG_MARGIN:   margin_r   <= cfg_wdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // entry count
  always_comb begin
    entry_count_nxt = entry_count_r;
    if (clear_acc) begin
      entry_count_nxt = '0;
    end else if (append_acc) begin
      entry_count_nxt = entry_count_r + CNT_W'(1);
    end
  end

  // busy from find accept until the token leaves the last cell
  always_comb begin
    busy_nxt = busy_r;
    if (find_acc) begin
      busy_nxt = 1'b1;
    end else if (tok[MAX_TONES].valid) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      busy_r        <= 1'b0;
    end else begin
      entry_count_r <= entry_count_nxt;
      busy_r        <= busy_nxt;
    end
  end

  // token injected into the first cell straight from the accepted find
  always_comb begin
    tok[0].valid = find_acc;
    tok[0].hit   = 1'b0;
    tok[0].freq  = in_data.frequency_hz;
    tok[0].tone  = '0;
    tok[0].label = '0;
  end

  for (genvar i = 0; i < MAX_TONES; i++) begin : g_cell
    cell_ctl_t         ctl;
    logic [FREQ_W-1:0] prev_t, next_t;
    logic              wr_en;

    // entry i is live below the count; first and last use the register edges
    assign ctl.active  = entry_count_r > CNT_W'(i);
    assign ctl.use_min = (i == 0);
    assign ctl.use_max = entry_count_r == CNT_W'(i + 1);
    assign wr_en       = append_acc && (entry_count_r == CNT_W'(i));

    if (i == 0) begin : g_first
      assign prev_t = '0;
    end else begin : g_mid
      assign prev_t = tone_w[i-1];
    end
    if (i == MAX_TONES - 1) begin : g_last
      assign next_t = '0;
    end else begin : g_inner
      assign next_t = tone_w[i+1];
    end

    tnc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (wr_en),
      .wr_tone   (in_data.frequency_hz),
      .wr_label  (in_data.tone_label),
      .ctl       (ctl),
      .min_freq  (min_freq_r),
      .max_freq  (max_freq_r),
      .prev_tone (prev_t),
      .next_tone (next_t),
      .tone      (tone_w[i]),
      .tok_in    (tok[i]),
      .tok_out   (tok[i+1])
    );
  end

  // result stage, one-cycle strobe
  tnc_format u_format (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (tok[MAX_TONES]),
    .margin    (margin_r),
    .res_valid (out_valid),
    .res_data  (out_data)
  );

  assign busy = busy_r;

endmodule

>>> rtl/tnc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnc_cell
// one table entry plus its band test; passes the query token on each cycle
// ----------------------------------------------------------------------------
module tnc_cell
  import tnc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [FREQ_W-1:0]  wr_tone,
  input  logic [LABEL_W-1:0] wr_label,
  input  cell_ctl_t          ctl,
  input  logic [FREQ_W-1:0]  min_freq,
  input  logic [FREQ_W-1:0]  max_freq,
  input  logic [FREQ_W-1:0]  prev_tone,
  input  logic [FREQ_W-1:0]  next_tone,
  output logic [FREQ_W-1:0]  tone,
  input  token_t             tok_in,
  output token_t             tok_out
);

  logic [FREQ_W-1:0]  tone_r;
  logic [LABEL_W-1:0] label_r;
  token_t             tok_r, tok_nxt;

  logic [FREQ_W:0] twice;
  logic [FREQ_W:0] sum_lo, sum_hi;
  logic            above_low, below_high, match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tone_r  <= wr_tone;
      label_r <= wr_label;
    end
  end

  assign twice  = {tok_in.freq, 1'b0};
  assign sum_lo = {1'b0, prev_tone} + {1'b0, tone_r};
  assign sum_hi = {1'b0, tone_r} + {1'b0, next_tone};

  always_comb begin
    above_low  = ctl.use_min ? (tok_in.freq >= min_freq) : (twice >= sum_lo);
    below_high = ctl.use_max ? (tok_in.freq < max_freq) : (twice < sum_hi);
    match      = tok_in.valid && !tok_in.hit && ctl.active && above_low && below_high;
    tok_nxt    = tok_in;
    if (match) begin
      tok_nxt.hit   = 1'b1;
      tok_nxt.tone  = tone_r;
      tok_nxt.label = label_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.hit   <= tok_nxt.hit;
    tok_r.freq  <= tok_nxt.freq;
    tok_r.tone  <= tok_nxt.tone;
    tok_r.label <= tok_nxt.label;
  end

  assign tone    = tone_r;
  assign tok_out = tok_r;

endmodule

>>> rtl/tnc_format.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnc_format
// turns the token leaving the cell row into the display result
// ----------------------------------------------------------------------------
module tnc_format
  import tnc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  token_t              tok,
  input  logic [MARGIN_W-1:0] margin,
  output logic                res_valid,
  output tnc_out_t            res_data
);

  logic        res_valid_r;
  tnc_out_t    res_data_r, res_data_nxt;
  logic [FREQ_W:0] f_plus_m, t_plus_m;

  assign f_plus_m = {1'b0, tok.freq} + (FREQ_W+1)'(margin);
  assign t_plus_m = {1'b0, tok.tone} + (FREQ_W+1)'(margin);

  always_comb begin
    if (!tok.hit) begin
      res_data_nxt.display_text = TEXT_NONE;
      res_data_nxt.pitch_status = ST_NONE;
      res_data_nxt.color_code   = COL_WHITE;
    end else if (f_plus_m < {1'b0, tok.tone}) begin
      res_data_nxt.display_text = {tok.label, CH_MINUS};
      res_data_nxt.pitch_status = ST_FLAT;
      res_data_nxt.color_code   = COL_RED;
    end else if ({1'b0, tok.freq} > t_plus_m) begin
      // two-letter label: mark as "+-"
      if (tok.label[7:0] == CH_SPACE) begin
        res_data_nxt.display_text = {tok.label[23:8], CH_PLUS, CH_MINUS};
      end else begin
        res_data_nxt.display_text = {tok.label, CH_PLUS};
      end
      res_data_nxt.pitch_status = ST_SHARP;
      res_data_nxt.color_code   = COL_RED;
    end else begin
      res_data_nxt.display_text = {tok.label, CH_SPACE};
      res_data_nxt.pitch_status = ST_INTUNE;
      res_data_nxt.color_code   = COL_GREEN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= tok.valid;
    end
    res_data_r <= res_data_nxt;
  end

  assign res_valid = res_valid_r;
  assign res_data  = res_data_r;

endmodule

>>> rtl/tnc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnc_checker
// port-level checks on the tuner note classifier, bound to the top level
// ----------------------------------------------------------------------------
`include "tuner_note_classifier_assert.svh"

module tnc_checker
  import tnc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input tnc_in_t               in_data,
  input logic                  out_valid,
  input tnc_out_t              out_data
);

  // a find holds the block busy, other transactions never do
  `TNC_ASSERT_NEXT(a_find_busy, clk, rst_n, start && !busy && in_data.req_type == REQ_FIND, busy, "find did not raise busy")
  `TNC_ASSERT_NEXT(a_other_idle, clk, rst_n, start && !busy && in_data.req_type != REQ_FIND, !busy, "non-find transaction raised busy")
  // result strobe ends the busy phase and lasts one cycle
  `TNC_ASSERT_IMP(a_out_idle, clk, rst_n, out_valid, !busy, "result shown while busy")
  `TNC_ASSERT_NEXT(a_out_pulse, clk, rst_n, out_valid, !out_valid, "result strobe longer than one cycle")
  // white only with no matching band
  `TNC_ASSERT_IMP(a_none_white, clk, rst_n, out_valid, (out_data.pitch_status == ST_NONE) == (out_data.color_code == COL_WHITE), "status and color disagree")

endmodule

bind tuner_note_classifier tnc_checker u_tnc_checker (.*);
